// File: sv/doubly_linked_list_engine_unit_macros.svh
// Assertion shorthands for the list engine; each expects clk and rst in scope.
`ifndef DOUBLY_LINKED_LIST_ENGINE_UNIT_MACROS_SVH
`define DOUBLY_LINKED_LIST_ENGINE_UNIT_MACROS_SVH

// condition holds at every edge out of reset
`define DLLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define DLLE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DLLE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dlle_pkg.sv
package dlle_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT   = 3'd0,
    CMD_PUSH_BACK    = 3'd1,
    CMD_INSERT_AFTER = 3'd2,
    CMD_POP_FRONT    = 3'd3,
    CMD_POP_BACK     = 3'd4,
    CMD_DELETE       = 3'd5,
    CMD_SEARCH       = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_ALLOC,
    S_TAKE,
    S_LINK,
    S_UNLINK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]                command;
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;
    logic               empty_res;
  } res_t;

  // per-field write enables of the node store
  typedef struct packed {
    logic value_we;
    logic next_we;
    logic prev_we;
  } node_we_t;

  // free list controls
  typedef struct packed {
    logic rd_en;      // fetch top of stack
    logic take;       // commit an allocation
    logic give_back;  // return a node
  } free_ctl_t;

endpackage

// File: sv/dlle_node_mem.sv
module dlle_node_mem #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                   clk,
  input  logic                                   rd_en,
  input  logic [$clog2(CAPACITY)-1:0]            rd_addr,
  output logic signed [dlle_pkg::VALUE_W-1:0]    rd_value,
  output logic [$clog2(CAPACITY+1)-1:0]          rd_next,
  output logic [$clog2(CAPACITY+1)-1:0]          rd_prev,
  input  dlle_pkg::node_we_t                     we,
  input  logic [$clog2(CAPACITY)-1:0]            value_addr,
  input  logic signed [dlle_pkg::VALUE_W-1:0]    value_wdata,
  input  logic [$clog2(CAPACITY)-1:0]            next_addr,
  input  logic [$clog2(CAPACITY+1)-1:0]          next_wdata,
  input  logic [$clog2(CAPACITY)-1:0]            prev_addr,
  input  logic [$clog2(CAPACITY+1)-1:0]          prev_wdata
);
  import dlle_pkg::*;

  localparam int unsigned LW = $clog2(CAPACITY + 1);

  logic signed [VALUE_W-1:0] value_mem [CAPACITY];
  logic [LW-1:0]             next_mem  [CAPACITY];
  logic [LW-1:0]             prev_mem  [CAPACITY];

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_value <= value_mem[rd_addr];
      rd_next  <= next_mem[rd_addr];
      rd_prev  <= prev_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (we.value_we) begin
      value_mem[value_addr] <= value_wdata;
    end
    if (we.next_we) begin
      next_mem[next_addr] <= next_wdata;
    end
    if (we.prev_we) begin
      prev_mem[prev_addr] <= prev_wdata;
    end
  end

endmodule

// File: sv/dlle_free_list.sv
module dlle_free_list #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dlle_pkg::free_ctl_t           ctl,
  input  logic [$clog2(CAPACITY)-1:0]   give_idx,
  output logic [$clog2(CAPACITY)-1:0]   take_idx,
  output logic                          free_none
);
  import dlle_pkg::*;

  localparam int unsigned NW = $clog2(CAPACITY);
  localparam int unsigned LW = $clog2(CAPACITY + 1);

  // Nodes never handed out are taken in index order from alloc_ptr; the
  // stack memory only ever holds nodes that came back, so it needs no init.
  logic [NW-1:0] stack_mem [CAPACITY];
  logic [NW-1:0] stack_rdata;
  logic [LW-1:0] free_top;
  logic [LW-1:0] alloc_ptr;
  logic [LW-1:0] top_m1;
  logic          from_stack;

  assign top_m1     = free_top - 1'b1;
  assign from_stack = ({1'b0, free_top} + {1'b0, alloc_ptr}) > (LW + 1)'(CAPACITY);
  assign take_idx   = from_stack ? stack_rdata : alloc_ptr[NW-1:0];
  assign free_none  = (free_top == '0);

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      stack_rdata <= stack_mem[top_m1[NW-1:0]];
    end
    if (ctl.give_back && (free_top < LW'(CAPACITY))) begin
      stack_mem[free_top[NW-1:0]] <= give_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_top  <= LW'(CAPACITY);
      alloc_ptr <= '0;
    end else if (ctl.take) begin
      free_top <= top_m1;
      if (!from_stack) begin
        alloc_ptr <= alloc_ptr + 1'b1;
      end
    end else if (ctl.give_back && (free_top < LW'(CAPACITY))) begin
      free_top <= free_top + 1'b1;
    end
  end

endmodule

// File: sv/dlle_ctrl.sv
`include "doubly_linked_list_engine_unit_macros.svh"

module dlle_ctrl #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dlle_pkg::req_t                      in_data,
  output logic                                res_valid,
  input  logic                                res_ready,
  output dlle_pkg::res_t                      res_data,
  // node store
  output logic                                mem_rd_en,
  output logic [$clog2(CAPACITY)-1:0]         mem_rd_addr,
  input  logic signed [dlle_pkg::VALUE_W-1:0] rd_value,
  input  logic [$clog2(CAPACITY+1)-1:0]       rd_next,
  input  logic [$clog2(CAPACITY+1)-1:0]       rd_prev,
  output dlle_pkg::node_we_t                  we,
  output logic [$clog2(CAPACITY)-1:0]         value_addr,
  output logic signed [dlle_pkg::VALUE_W-1:0] value_wdata,
  output logic [$clog2(CAPACITY)-1:0]         next_addr,
  output logic [$clog2(CAPACITY+1)-1:0]       next_wdata,
  output logic [$clog2(CAPACITY)-1:0]         prev_addr,
  output logic [$clog2(CAPACITY+1)-1:0]       prev_wdata,
  // free list
  output dlle_pkg::free_ctl_t                 free_ctl,
  output logic [$clog2(CAPACITY)-1:0]         give_idx,
  input  logic [$clog2(CAPACITY)-1:0]         take_idx,
  input  logic                                free_none
);
  import dlle_pkg::*;

  localparam int unsigned NW = $clog2(CAPACITY);
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);
  localparam logic [NW-1:0] LAST_STEP = NW'(CAPACITY - 1);

  state_t        state, state_next;
  req_t          req, req_next;
  logic [LW-1:0] head, head_next;
  logic [LW-1:0] tail, tail_next;
  logic [LW-1:0] count, count_next;
  logic [NW-1:0] cur, cur_next;
  logic [NW-1:0] steps, steps_next;
  logic [NW-1:0] new_idx, new_idx_next;
  status_t       res_status, res_status_next;
  logic          res_found, res_found_next;
  logic [NW-1:0] res_pos, res_pos_next;

  logic                      head_nil, tail_nil, list_empty, full, match, next_nil;
  logic signed [VALUE_W-1:0] target;

  assign head_nil   = (head >= NIL);
  assign tail_nil   = (tail >= NIL);
  assign list_empty = head_nil || tail_nil;
  assign full       = free_none || (count >= NIL);
  assign target     = (req.command == CMD_INSERT_AFTER) ? req.key : req.value;
  assign match      = (rd_value == target);
  assign next_nil   = (rd_next >= NIL);

  assign res_data.status    = res_status;
  assign res_data.found     = res_found;
  assign res_data.position  = POS_W'(res_pos);
  assign res_data.count     = COUNT_W'(count);
  assign res_data.empty_res = (count == '0);
  assign give_idx           = cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= NIL;
      tail  <= NIL;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    req        <= req_next;
    cur        <= cur_next;
    steps      <= steps_next;
    new_idx    <= new_idx_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    res_pos    <= res_pos_next;
  end

  always_comb begin
    state_next      = state;
    req_next        = req;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    cur_next        = cur;
    steps_next      = steps;
    new_idx_next    = new_idx;
    res_status_next = res_status;
    res_found_next  = res_found;
    res_pos_next    = res_pos;
    in_ready        = 1'b0;
    res_valid       = 1'b0;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = cur;
    we              = '0;
    value_addr      = take_idx;
    value_wdata     = req.value;
    next_addr       = take_idx;
    next_wdata      = NIL;
    prev_addr       = take_idx;
    prev_wdata      = NIL;
    free_ctl        = '0;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_next   = in_data;
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        res_status_next = ST_OK;
        res_found_next  = 1'b0;
        res_pos_next    = '0;
        steps_next      = '0;
        cur_next        = head[NW-1:0];
        case (req.command)
          CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (full) begin
              res_status_next = ST_FULL;
              state_next      = S_DONE;
            end else begin
              state_next = S_ALLOC;
            end
          end
          CMD_INSERT_AFTER, CMD_DELETE, CMD_SEARCH: begin
            if (head_nil) begin
              res_status_next = ST_NOT_FOUND;
              state_next      = S_DONE;
            end else begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = head[NW-1:0];
              state_next  = S_WALK;
            end
          end
          CMD_POP_FRONT: begin
            if (head_nil) begin
              res_status_next = ST_EMPTY;
              state_next      = S_DONE;
            end else begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = head[NW-1:0];
              state_next  = S_UNLINK;
            end
          end
          CMD_POP_BACK: begin
            if (tail_nil) begin
              res_status_next = ST_EMPTY;
              state_next      = S_DONE;
            end else begin
              cur_next    = tail[NW-1:0];
              mem_rd_en   = 1'b1;
              mem_rd_addr = tail[NW-1:0];
              state_next  = S_UNLINK;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end

      // one node per cycle: the read of the next node issues straight off
      // the forward link that just came out of the store
      S_WALK: begin
        if (match) begin
          res_found_next = 1'b1;
          res_pos_next   = steps;
          case (req.command)
            CMD_DELETE: state_next = S_UNLINK;
            CMD_INSERT_AFTER: begin
              if (full) begin
                res_status_next = ST_FULL;
                state_next      = S_DONE;
              end else begin
                state_next = S_ALLOC;
              end
            end
            default: state_next = S_DONE;
          endcase
        end else if (next_nil || (steps == LAST_STEP)) begin
          res_status_next = ST_NOT_FOUND;
          state_next      = S_DONE;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = rd_next[NW-1:0];
          cur_next    = rd_next[NW-1:0];
          steps_next  = steps + 1'b1;
        end
      end

      S_ALLOC: begin
        free_ctl.rd_en = 1'b1;
        state_next     = S_TAKE;
      end

      // write the whole new node; neighbors are patched in S_LINK
      S_TAKE: begin
        free_ctl.take = 1'b1;
        count_next    = count + 1'b1;
        new_idx_next  = take_idx;
        we            = '{value_we: 1'b1, next_we: 1'b1, prev_we: 1'b1};
        case (req.command)
          CMD_PUSH_FRONT: begin
            if (!list_empty) begin
              next_wdata = head;
            end
          end
          CMD_PUSH_BACK: begin
            if (!list_empty) begin
              prev_wdata = tail;
            end
          end
          default: begin
            next_wdata = rd_next;
            prev_wdata = LW'(cur);
          end
        endcase
        state_next = S_LINK;
      end

      S_LINK: begin
        next_wdata = LW'(new_idx);
        prev_wdata = LW'(new_idx);
        case (req.command)
          CMD_PUSH_FRONT: begin
            if (list_empty) begin
              tail_next = LW'(new_idx);
            end else begin
              we.prev_we = 1'b1;
              prev_addr  = head[NW-1:0];
            end
            head_next = LW'(new_idx);
          end
          CMD_PUSH_BACK: begin
            if (list_empty) begin
              head_next = LW'(new_idx);
            end else begin
              we.next_we = 1'b1;
              next_addr  = tail[NW-1:0];
            end
            tail_next = LW'(new_idx);
          end
          default: begin
            we.next_we = 1'b1;
            next_addr  = cur;
            if (next_nil) begin
              tail_next = LW'(new_idx);
            end else begin
              we.prev_we = 1'b1;
              prev_addr  = rd_next[NW-1:0];
            end
          end
        endcase
        state_next = S_DONE;
      end

      // node cur leaves; its links are in the read register
      S_UNLINK: begin
        next_wdata = rd_next;
        prev_wdata = rd_prev;
        next_addr  = rd_prev[NW-1:0];
        prev_addr  = rd_next[NW-1:0];
        if (rd_prev >= NIL) begin
          head_next = rd_next;
        end else begin
          we.next_we = 1'b1;
        end
        if (next_nil) begin
          tail_next = rd_prev;
        end else begin
          we.prev_we = 1'b1;
        end
        free_ctl.give_back = 1'b1;
        if (count != '0) begin
          count_next = count - 1'b1;
        end
        state_next = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `DLLE_ASSERT(a_count_range, count <= NIL, "node count above capacity")
  `DLLE_ASSERT_IMP(a_idle_shape, state == S_IDLE, ((count == '0) == head_nil) && (head_nil == tail_nil), "head, tail and count disagree")
  `DLLE_ASSERT_IMP(a_take_has_room, state == S_TAKE, !full, "allocation from a full pool")
  `DLLE_ASSERT(a_no_rw_overlap, !(mem_rd_en && (we.value_we || we.next_we || we.prev_we)), "node read and write in one cycle")
  `DLLE_ASSERT_NXT(a_unlink_shrinks, (state == S_UNLINK) && (count != '0), count == ($past(count) - 1'b1), "unlink did not drop the count")

endmodule

// File: sv/doubly_linked_list_engine_unit.sv
// Doubly linked list engine: keeps an ordered list of signed 32-bit values
// in a pool of CAPACITY nodes (values and both links in a registered-read
// node store, free nodes on a stack with a fill pointer, so no clearing pass
// is needed after reset; reset simply empties the list). Each request carries
// a command (push front/back, insert after key, pop front/back, delete value,
// search) and returns exactly one result with status, found flag, position
// of the first match from the head, node count and empty flag. Requests are
// taken one at a time; the next one is accepted while the previous result
// still sits in the output register. A request with an unused command code
// or one refused up front (push into a full pool, pop of an empty list,
// lookup in an empty list) goes straight to its result. Search, delete and
// insert-after first walk the list from the head until the first match (a
// miss walks every node; insert-after into a full pool stops after the
// walk). The worst case is set by the list walk, which reads one node per
// cycle from the single read port of the node store.
module doubly_linked_list_engine_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dlle_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output dlle_pkg::res_t  out_data
);
  import dlle_pkg::*;

  localparam int unsigned NW = $clog2(CAPACITY);
  localparam int unsigned LW = $clog2(CAPACITY + 1);

  // result handoff from the sequencer into the output register
  logic res_valid, res_ready;
  res_t res_data;

  // node store
  logic                      mem_rd_en;
  logic [NW-1:0]             mem_rd_addr;
  logic signed [VALUE_W-1:0] rd_value;
  logic [LW-1:0]             rd_next, rd_prev;
  node_we_t                  we;
  logic [NW-1:0]             value_addr, next_addr, prev_addr;
  logic signed [VALUE_W-1:0] value_wdata;
  logic [LW-1:0]             next_wdata, prev_wdata;

  // free list
  free_ctl_t     free_ctl;
  logic [NW-1:0] give_idx, take_idx;
  logic          free_none;

  dlle_node_mem #(.CAPACITY(CAPACITY)) u_node_mem (
    .clk         (clk),
    .rd_en       (mem_rd_en),
    .rd_addr     (mem_rd_addr),
    .rd_value    (rd_value),
    .rd_next     (rd_next),
    .rd_prev     (rd_prev),
    .we          (we),
    .value_addr  (value_addr),
    .value_wdata (value_wdata),
    .next_addr   (next_addr),
    .next_wdata  (next_wdata),
    .prev_addr   (prev_addr),
    .prev_wdata  (prev_wdata)
  );

  dlle_free_list #(.CAPACITY(CAPACITY)) u_free_list (
    .clk       (clk),
    .rst       (rst),
    .ctl       (free_ctl),
    .give_idx  (give_idx),
    .take_idx  (take_idx),
    .free_none (free_none)
  );

  dlle_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .rd_value    (rd_value),
    .rd_next     (rd_next),
    .rd_prev     (rd_prev),
    .we          (we),
    .value_addr  (value_addr),
    .value_wdata (value_wdata),
    .next_addr   (next_addr),
    .next_wdata  (next_wdata),
    .prev_addr   (prev_addr),
    .prev_wdata  (prev_wdata),
    .free_ctl    (free_ctl),
    .give_idx    (give_idx),
    .take_idx    (take_idx),
    .free_none   (free_none)
  );

  // Output register: the sequencer may finish a result only when this slot
  // is empty or is being drained in the same cycle.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res_data;
    end
  end

endmodule

// File: tb/sv/doubly_linked_list_engine_unit_test.sv
module doubly_linked_list_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dlle_pkg::*;

  // Pool size of the block under test.
  localparam int POOL_SIZE = 16;
  // Command code with no meaning; the block must answer it and change nothing.
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  // Random requests wanted after the directed part (unused codes not counted).
  localparam int RANDOM_REQUESTS = 1550;
  // Requests near the end of the run go without any idling on either side.
  localparam int CALM_TAIL = 150;
  // A request's worst case is its longest list walk plus random idling on each side;
  // this limit is several times that for the whole run.
  localparam int CYCLE_LIMIT = 400000;
  // Settling time after the last result, well above the longest list walk.
  localparam int DRAIN_CYCLES = 40;

  // A queued request; wait_drain holds it back until no result is outstanding.
  typedef struct {
    req_t req;
    bit   wait_drain;
  } list_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  res_t out_data;

  list_req_t list_cmd_q[$];          // requests not yet presented
  res_t results_due[$];              // predicted results, oldest first
  logic signed [31:0] list_model[$]; // shadow of the list, head at index 0
  logic signed [31:0] operand_pool[8];

  int in_flight = 0;      // accepted requests whose result has not come back
  int failures = 0;
  int total_requests = 0;
  int unsigned cycles = 0;

  doubly_linked_list_engine_unit #(
    .CAPACITY (POOL_SIZE)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor. Only the order of values matters for the result fields, so the
  // list is kept as a plain queue of values; node placement in the pool and the
  // free stack order are invisible from the ports.
  // ---------------------------------------------------------------------------

  // Place of the first node holding v, counted from the head; -1 when absent.
  function automatic int locate_value(logic signed [31:0] v);
    for (int i = 0; i < list_model.size(); i++) begin
      if (list_model[i] == v) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic res_t apply_list_command(req_t rq);
    res_t r;
    int at;
    bit full;
    r = '0;
    r.status = ST_OK;
    full = (list_model.size() >= POOL_SIZE);
    case (rq.command)
      CMD_PUSH_FRONT: begin
        if (full) r.status = ST_FULL;
        else list_model.push_front(rq.value);
      end
      CMD_PUSH_BACK: begin
        if (full) r.status = ST_FULL;
        else list_model.push_back(rq.value);
      end
      CMD_INSERT_AFTER: begin
        at = locate_value(rq.key);
        if (at < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          // key position is reported even when the pool is full
          r.found = 1'b1;
          r.position = 4'(at);
          if (full) r.status = ST_FULL;
          else list_model.insert(at + 1, rq.value);
        end
      end
      CMD_POP_FRONT: begin
        if (list_model.size() == 0) r.status = ST_EMPTY;
        else void'(list_model.pop_front());
      end
      CMD_POP_BACK: begin
        if (list_model.size() == 0) r.status = ST_EMPTY;
        else void'(list_model.pop_back());
      end
      CMD_DELETE, CMD_SEARCH: begin
        at = locate_value(rq.value);
        if (at < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.found = 1'b1;
          r.position = 4'(at);
          if (rq.command == CMD_DELETE) list_model.delete(at);
        end
      end
      default: ; // unused code: no change, status ok
    endcase
    r.count = 5'(list_model.size());
    r.empty_res = (list_model.size() == 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_request(logic [2:0] cmd, logic signed [31:0] value,
                               logic signed [31:0] key, bit wait_drain);
    list_req_t item;
    item.req.command = cmd;
    item.req.value = value;
    item.req.key = key;
    item.wait_drain = wait_drain;
    list_cmd_q.push_back(item);
  endtask

  // Operands come mostly from a small pool so that searches, deletes and keys
  // hit nodes in the list; the pool is refreshed with full-range values.
  function automatic logic signed [31:0] pick_operand();
    int unsigned r;
    int unsigned slot;
    r = $urandom_range(0, 99);
    slot = $urandom_range(0, 7);
    if (r < 5) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    if (r < 20) operand_pool[slot] = $urandom();
    return operand_pool[slot];
  endfunction

  // Command mix per kind of sequence: 0 grows the list toward full, 1 drains
  // it, 2 is lookup heavy, 3 is noise over every code.
  function automatic logic [2:0] pick_command(int kind);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (kind)
      0: begin
        if (r < 35) return CMD_PUSH_FRONT;
        if (r < 70) return CMD_PUSH_BACK;
        if (r < 80) return CMD_INSERT_AFTER;
        if (r < 87) return CMD_POP_FRONT;
        if (r < 94) return CMD_POP_BACK;
        return CMD_SEARCH;
      end
      1: begin
        if (r < 10) return CMD_PUSH_FRONT;
        if (r < 20) return CMD_PUSH_BACK;
        if (r < 25) return CMD_INSERT_AFTER;
        if (r < 50) return CMD_POP_FRONT;
        if (r < 75) return CMD_POP_BACK;
        if (r < 92) return CMD_DELETE;
        return CMD_SEARCH;
      end
      2: begin
        if (r < 15) return CMD_PUSH_BACK;
        if (r < 25) return CMD_INSERT_AFTER;
        if (r < 55) return CMD_SEARCH;
        if (r < 85) return CMD_DELETE;
        if (r < 92) return CMD_POP_FRONT;
        return CMD_PUSH_FRONT;
      end
      default: return 3'($urandom_range(0, 7));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: presents queued requests, predicts each one as it is
  // accepted, and idles in random bursts.
  // ---------------------------------------------------------------------------
  int gap_left = 0;
  int idle_pct = 0;
  int sent = 0;

  always @(posedge clk) begin : drive_requests
    logic fire;
    logic drive_valid;
    req_t drive_data;
    list_req_t nxt;
    fire = in_valid && in_ready;
    drive_valid = in_valid;
    drive_data = in_data;
    if (rst) begin
      drive_valid = 1'b0;
    end else begin
      if (fire) begin
        results_due.push_back(apply_list_command(in_data));
        in_flight++;
        sent++;
        // new idling mix every so often, some stretches with none at all
        if (sent % 64 == 0) begin
          case ($urandom_range(0, 3))
            0: idle_pct = 0;
            1: idle_pct = 5;
            2: idle_pct = 15;
            default: idle_pct = 35;
          endcase
        end
      end
      if (out_valid && out_ready) in_flight--;
      if (list_cmd_q.size() < CALM_TAIL) begin
        idle_pct = 0;
        gap_left = 0;
      end

      // a held request stays up until it is taken
      if (!in_valid || fire) begin
        drive_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (list_cmd_q.size() == 0) begin
          // nothing left to send
        end else if (list_cmd_q[0].wait_drain && in_flight != 0) begin
          // sender pause: wait for every outstanding result
        end else if ($urandom_range(0, 99) < idle_pct) begin
          gap_left = $urandom_range(1, 15) - 1;
        end else begin
          nxt = list_cmd_q.pop_front();
          drive_valid = 1'b1;
          drive_data = nxt.req;
        end
      end
    end
    in_valid <= drive_valid;
    in_data <= drive_data;
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks every accepted result against the oldest prediction
  // and stalls out_ready in random bursts.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int stall_pct = 0;
  int checked = 0;

  always @(posedge clk) begin : check_results
    res_t want;
    logic take;
    take = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        checked++;
        if (results_due.size() == 0) begin
          $error("result with no request outstanding: %p", out_data);
          failures++;
        end else begin
          want = results_due.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            failures++;
          end
          if (out_data.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_data.found);
            failures++;
          end
          if (out_data.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_data.position);
            failures++;
          end
          if (out_data.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_data.count);
            failures++;
          end
          if (out_data.empty_res !== want.empty_res) begin
            $error("empty_res: expected %0d, got %0d", want.empty_res, out_data.empty_res);
            failures++;
          end
        end
        if (checked % 64 == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 5;
            2: stall_pct = 15;
            default: stall_pct = 35;
          endcase
        end
      end
      if (checked + CALM_TAIL >= total_requests) begin
        stall_pct = 0;
        stall_left = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 15) - 1;
      end else begin
        take = 1'b1;
      end
    end
    out_ready <= take;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int random_count;
    int block_idx;
    int kind;
    logic [2:0] cmd;
    random_count = 0;
    block_idx = 0;
    foreach (operand_pool[i]) operand_pool[i] = $urandom();

    // Directed: empty list corner cases
    queue_request(CMD_POP_FRONT, 32'sh0, 32'sh0, 1'b0);
    queue_request(CMD_POP_BACK, 32'sh0, 32'sh0, 1'b0);
    queue_request(CMD_SEARCH, 32'sh0, 32'sh0, 1'b0);
    queue_request(CMD_DELETE, -32'sd1, 32'sh0, 1'b0);
    queue_request(CMD_INSERT_AFTER, 32'sh1, 32'sh0, 1'b0);
    // Directed: extremes of the value field, both ends of the list
    queue_request(CMD_PUSH_BACK, 32'sh7fff_ffff, 32'sh0, 1'b0);
    queue_request(CMD_PUSH_FRONT, 32'sh8000_0000, 32'sh0, 1'b0);
    queue_request(CMD_PUSH_BACK, 32'sh0, 32'sh0, 1'b0);
    queue_request(CMD_PUSH_FRONT, -32'sd1, 32'sh0, 1'b0);
    // insert after the tail: new node must become the tail
    queue_request(CMD_INSERT_AFTER, 32'sh5, 32'sh0, 1'b0);
    queue_request(CMD_POP_BACK, 32'sh0, 32'sh0, 1'b0);
    queue_request(CMD_SEARCH, 32'sh8000_0000, 32'sh0, 1'b0);
    queue_request(CMD_INSERT_AFTER, 32'sh5555_5555, -32'sd1, 1'b0);
    queue_request(CMD_INSERT_AFTER, 32'sh2, 32'sh1234_5678, 1'b0);
    // duplicates: only the first match from the head counts
    queue_request(CMD_PUSH_BACK, -32'sd1, 32'sh0, 1'b0);
    queue_request(CMD_SEARCH, -32'sd1, 32'sh0, 1'b0);
    queue_request(CMD_DELETE, -32'sd1, 32'sh0, 1'b0);
    queue_request(CMD_SEARCH, -32'sd1, 32'sh0, 1'b0);
    queue_request(CMD_DELETE, 32'sh1234_5678, 32'sh0, 1'b0);
    queue_request(CMD_UNUSED, 32'shffff_ffff, 32'shffff_ffff, 1'b0);
    // drain down to one node, then push a node to the front and delete it again
    queue_request(CMD_DELETE, 32'sh7fff_ffff, 32'sh0, 1'b0);
    queue_request(CMD_POP_FRONT, 32'sh0, 32'sh0, 1'b0);
    queue_request(CMD_POP_BACK, 32'sh0, 32'sh0, 1'b0);
    queue_request(CMD_POP_FRONT, 32'sh0, 32'sh0, 1'b0);
    queue_request(CMD_PUSH_FRONT, 32'sh7, 32'sh0, 1'b0);
    queue_request(CMD_DELETE, 32'sh7, 32'sh0, 1'b0);

    // Random part in blocks of 40; the first block grows the list toward full.
    // Some blocks start with a sender pause until all results are back.
    while (random_count < RANDOM_REQUESTS) begin
      kind = (block_idx == 0) ? 0 : $urandom_range(0, 9);
      if (kind < 3) kind = 0;
      else if (kind < 6) kind = 1;
      else if (kind < 9) kind = 2;
      else kind = 3;
      for (int i = 0; i < 40; i++) begin
        cmd = pick_command(kind);
        if (kind == 3) begin
          queue_request(cmd, $urandom(), $urandom(), (i == 0) && (block_idx % 8 == 0));
        end else begin
          queue_request(cmd, pick_operand(), pick_operand(),
                        (i == 0) && (block_idx % 8 == 0));
        end
        if (cmd != CMD_UNUSED) random_count++;
      end
      block_idx++;
    end
    total_requests = list_cmd_q.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (list_cmd_q.size() != 0 || in_valid || in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (results_due.size() != 0) begin
      $error("%0d predicted results never arrived", results_due.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
